/* hw/rtl/jhp_pkg.sv */
// JPEG header parser package: phase, record kind, status and marker codes,
// the record and state types. Used by jhp_step and jpeg_header_parser_core.
`default_nettype none
package jhp_pkg;
    localparam int OFFSET_BITS    = 24;
    localparam int MAX_COMPONENTS = 4;

    localparam logic [4:0] P_SOI0 = 5'd0, P_SOI1 = 5'd1, P_MARK = 5'd2, P_CODE = 5'd3,
        P_LEN_HI = 5'd4, P_LEN_LO = 5'd5, P_SOF_PREC = 5'd6, P_SOF_DIM = 5'd7,
        P_SOF_NC = 5'd8, P_SOF_COMP = 5'd9, P_DQT_HEAD = 5'd10, P_DQT_DATA = 5'd11,
        P_DHT_HEAD = 5'd12, P_DHT_COUNT = 5'd13, P_DHT_VAL = 5'd14, P_DRI = 5'd15,
        P_SOS_NS = 5'd16, P_SOS_COMP = 5'd17, P_SKIP = 5'd18, P_SCAN = 5'd19,
        P_ERROR = 5'd20;

    localparam logic [3:0] K_DIMS = 4'd0, K_SOF_COMP = 4'd1, K_QUANT = 4'd2,
        K_HUFF_COUNT = 4'd3, K_HUFF_VALUE = 4'd4, K_HUFF_DONE = 4'd5, K_RESTART = 4'd6,
        K_SCAN_COMP = 4'd7, K_FINAL = 4'd8;

    localparam logic [3:0] S_OK = 4'd0, S_BAD_START = 4'd1, S_NO_MARKER = 4'd2,
        S_BAD_LENGTH = 4'd3, S_PRECISION = 4'd4, S_COMP_COUNT = 4'd5, S_TABLE_ID = 4'd6,
        S_SHORT = 4'd7, S_TRUNCATED = 4'd8, S_NO_SCAN = 4'd9, S_OVERSIZE = 4'd10;

    localparam logic [7:0] M_FF = 8'hFF, M_SOI = 8'hD8, M_EOI = 8'hD9, M_SOF0 = 8'hC0,
        M_DHT = 8'hC4, M_DQT = 8'hDB, M_DRI = 8'hDD, M_SOS = 8'hDA;

    typedef struct packed {
        logic [3:0]             rec_kind;
        logic [1:0]             table_slot;
        logic [7:0]             entry_index;
        logic [15:0]            value;
        logic [15:0]            value_two;
        logic [7:0]             comp_ident;
        logic [3:0]             factor_a;
        logic [3:0]             factor_b;
        logic [3:0]             status;
        logic [OFFSET_BITS-1:0] scan_offset;
        logic [OFFSET_BITS-1:0] scan_length;
    } rec_t;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [4:0]             phase;
        logic [OFFSET_BITS-1:0] byte_count;
        logic [15:0]            segment_left;
        logic [7:0]             marker;
        logic [7:0]             length_high;
        logic [7:0]             sub_index;
        logic [1:0]             slot;
        logic [8:0]             huff_total;
        logic [2:0]             comp_index;
        logic [2:0]             comp_total;
        logic [15:0]            field_hold;
        logic [15:0]            frame_width;
        logic [3:0]             error_code;
        logic [OFFSET_BITS-1:0] scan_start;
        logic [15:0]            last_two;
    } pstate_t;
endpackage
`default_nettype wire

/* hw/rtl/jhp_step.sv */
// Next-state and record logic of the parser for one byte.
// Depends on jhp_pkg.
`default_nettype none
module jhp_step (
    input  wire jhp_pkg::pstate_t cur,
    input  wire logic [7:0]       data_byte,
    input  wire logic             file_end,
    output jhp_pkg::pstate_t      nxt,
    output jhp_pkg::rec_t         rec0,
    output jhp_pkg::rec_t         rec1,
    output jhp_pkg::rec_t         rec2,
    output logic [1:0]            rec_count
);
    localparam logic [jhp_pkg::OFFSET_BITS-1:0] OFF_MAX = '1;

    jhp_pkg::pstate_t s;
    jhp_pkg::rec_t    r [3];
    logic [1:0]  n;
    logic [7:0]  b;
    logic [15:0] rem_after;
    logic [15:0] len;
    logic [15:0] body;
    logic [9:0]  tot_sum;
    logic [8:0]  tot_sat;
    logic [8:0]  k_next;
    logic [OFFSET_BITS_W-1:0] size;
    logic [OFFSET_BITS_W-1:0] stop;
    logic [3:0]  st;
    logic        body_phase;
    localparam int OFFSET_BITS_W = jhp_pkg::OFFSET_BITS + 1;

    always_comb
    begin
        s = cur;
        b = data_byte;
        n = 2'd0;
        r[0] = '0;
        r[1] = '0;
        r[2] = '0;
        rem_after = (cur.segment_left != 16'd0) ? cur.segment_left - 16'd1 : 16'd0;
        len = {cur.length_high, b};
        body = len - 16'd2;
        tot_sum = {1'b0, cur.huff_total} + {2'b0, b};
        tot_sat = (tot_sum > 10'd257) ? 9'd257 : tot_sum[8:0];
        k_next = {1'b0, cur.sub_index} + 9'd1;
        size = {1'b0, cur.byte_count} + 1'b1;
        stop = size;
        st = jhp_pkg::S_OK;
        body_phase = 1'b0;
        s.last_two = {cur.last_two[7:0], b};
        if (cur.phase != jhp_pkg::P_ERROR && cur.byte_count >= OFF_MAX)
        begin
            s.error_code = jhp_pkg::S_OVERSIZE;
            s.phase = jhp_pkg::P_ERROR;
        end
        if (!(file_end && s.phase == jhp_pkg::P_MARK))
        begin
            unique case (s.phase)
                jhp_pkg::P_SOI0:
                    if (b != jhp_pkg::M_FF)
                    begin
                        s.error_code = jhp_pkg::S_BAD_START; s.phase = jhp_pkg::P_ERROR;
                    end
                    else s.phase = jhp_pkg::P_SOI1;
                jhp_pkg::P_SOI1:
                    if (b != jhp_pkg::M_SOI)
                    begin
                        s.error_code = jhp_pkg::S_BAD_START; s.phase = jhp_pkg::P_ERROR;
                    end
                    else s.phase = jhp_pkg::P_MARK;
                jhp_pkg::P_MARK:
                    if (b != jhp_pkg::M_FF)
                    begin
                        s.error_code = jhp_pkg::S_NO_MARKER; s.phase = jhp_pkg::P_ERROR;
                    end
                    else s.phase = jhp_pkg::P_CODE;
                jhp_pkg::P_CODE:
                    if (b == jhp_pkg::M_FF)
                        s.phase = jhp_pkg::P_CODE;
                    else if (b == jhp_pkg::M_SOI || b == jhp_pkg::M_EOI)
                        s.phase = jhp_pkg::P_MARK;
                    else
                    begin
                        s.marker = b; s.phase = jhp_pkg::P_LEN_HI;
                    end
                jhp_pkg::P_LEN_HI:
                begin
                    s.length_high = b; s.phase = jhp_pkg::P_LEN_LO;
                end
                jhp_pkg::P_LEN_LO:
                    if (len < 16'd2)
                    begin
                        s.error_code = jhp_pkg::S_BAD_LENGTH; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        s.segment_left = body;
                        priority case (cur.marker)
                            jhp_pkg::M_SOF0:
                                if (body < 16'd6)
                                begin
                                    s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                                end
                                else s.phase = jhp_pkg::P_SOF_PREC;
                            jhp_pkg::M_DQT:
                                s.phase = (body != 16'd0) ? jhp_pkg::P_DQT_HEAD : jhp_pkg::P_MARK;
                            jhp_pkg::M_DHT:
                                s.phase = (body != 16'd0) ? jhp_pkg::P_DHT_HEAD : jhp_pkg::P_MARK;
                            jhp_pkg::M_DRI:
                                if (body < 16'd2)
                                begin
                                    s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                                end
                                else
                                begin
                                    s.sub_index = 8'd0; s.phase = jhp_pkg::P_DRI;
                                end
                            jhp_pkg::M_SOS:
                                if (body < 16'd1)
                                begin
                                    s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                                end
                                else s.phase = jhp_pkg::P_SOS_NS;
                            default:
                                s.phase = (body != 16'd0) ? jhp_pkg::P_SKIP : jhp_pkg::P_MARK;
                        endcase
                    end
                jhp_pkg::P_SOF_PREC:
                begin
                    body_phase = 1'b1;
                    if (b != 8'd8)
                    begin
                        s.error_code = jhp_pkg::S_PRECISION; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        s.sub_index = 8'd0; s.field_hold = 16'd0; s.frame_width = 16'd0;
                        s.phase = jhp_pkg::P_SOF_DIM;
                    end
                end
                jhp_pkg::P_SOF_DIM:
                begin
                    body_phase = 1'b1;
                    if (cur.sub_index < 8'd2) s.field_hold = {cur.field_hold[7:0], b};
                    else s.frame_width = {cur.frame_width[7:0], b};
                    s.sub_index = cur.sub_index + 8'd1;
                    if (s.sub_index >= 8'd4) s.phase = jhp_pkg::P_SOF_NC;
                end
                jhp_pkg::P_SOF_NC:
                begin
                    body_phase = 1'b1;
                    if (b == 8'd0 || b > 8'(jhp_pkg::MAX_COMPONENTS))
                    begin
                        s.error_code = jhp_pkg::S_COMP_COUNT; s.phase = jhp_pkg::P_ERROR;
                    end
                    else if (rem_after < 16'(3 * b[2:0]))
                    begin
                        s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        r[0].rec_kind = jhp_pkg::K_DIMS;
                        r[0].entry_index = b;
                        r[0].value = cur.field_hold;
                        r[0].value_two = cur.frame_width;
                        n = 2'd1;
                        s.comp_total = b[2:0]; s.comp_index = 3'd0; s.sub_index = 8'd0;
                        s.phase = jhp_pkg::P_SOF_COMP;
                    end
                end
                jhp_pkg::P_SOF_COMP:
                begin
                    body_phase = 1'b1;
                    if (cur.sub_index == 8'd0)
                    begin
                        s.field_hold = {8'd0, b}; s.sub_index = 8'd1;
                    end
                    else if (cur.sub_index == 8'd1)
                    begin
                        s.field_hold = cur.field_hold | {b, 8'd0}; s.sub_index = 8'd2;
                    end
                    else
                    begin
                        r[0].rec_kind = jhp_pkg::K_SOF_COMP;
                        r[0].entry_index = {5'd0, cur.comp_index};
                        r[0].value = {8'd0, b};
                        r[0].comp_ident = cur.field_hold[7:0];
                        r[0].factor_a = cur.field_hold[15:12];
                        r[0].factor_b = cur.field_hold[11:8];
                        n = 2'd1;
                        s.sub_index = 8'd0;
                        s.comp_index = cur.comp_index + 3'd1;
                        if (s.comp_index >= cur.comp_total) s.phase = jhp_pkg::P_SKIP;
                    end
                end
                jhp_pkg::P_DQT_HEAD:
                begin
                    body_phase = 1'b1;
                    if (b[7:4] != 4'd0)
                    begin
                        s.error_code = jhp_pkg::S_PRECISION; s.phase = jhp_pkg::P_ERROR;
                    end
                    else if (b[3:0] >= 4'd4)
                    begin
                        s.error_code = jhp_pkg::S_TABLE_ID; s.phase = jhp_pkg::P_ERROR;
                    end
                    else if (rem_after < 16'd64)
                    begin
                        s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        s.slot = b[1:0]; s.sub_index = 8'd0; s.phase = jhp_pkg::P_DQT_DATA;
                    end
                end
                jhp_pkg::P_DQT_DATA:
                begin
                    body_phase = 1'b1;
                    r[0].rec_kind = jhp_pkg::K_QUANT;
                    r[0].table_slot = cur.slot;
                    r[0].entry_index = cur.sub_index;
                    r[0].value = {8'd0, b};
                    n = 2'd1;
                    s.sub_index = cur.sub_index + 8'd1;
                    if (s.sub_index >= 8'd64) s.phase = jhp_pkg::P_DQT_HEAD;
                end
                jhp_pkg::P_DHT_HEAD:
                begin
                    body_phase = 1'b1;
                    if (rem_after < 16'd16)
                        s.phase = jhp_pkg::P_SKIP;
                    else if (b[7:4] > 4'd1 || b[3:0] > 4'd1)
                    begin
                        s.error_code = jhp_pkg::S_TABLE_ID; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        s.slot = {b[4], b[0]}; s.huff_total = 9'd0; s.sub_index = 8'd0;
                        s.phase = jhp_pkg::P_DHT_COUNT;
                    end
                end
                jhp_pkg::P_DHT_COUNT:
                begin
                    body_phase = 1'b1;
                    r[0].rec_kind = jhp_pkg::K_HUFF_COUNT;
                    r[0].table_slot = cur.slot;
                    r[0].entry_index = cur.sub_index;
                    r[0].value = {8'd0, b};
                    n = 2'd1;
                    s.huff_total = tot_sat;
                    s.sub_index = cur.sub_index + 8'd1;
                    if (s.sub_index >= 8'd16)
                    begin
                        if (tot_sat > 9'd256)
                        begin
                            s.error_code = jhp_pkg::S_BAD_LENGTH; s.phase = jhp_pkg::P_ERROR;
                        end
                        else if (rem_after < {7'd0, tot_sat})
                        begin
                            s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                        end
                        else
                        begin
                            s.sub_index = 8'd0;
                            if (tot_sat == 9'd0)
                            begin
                                r[1].rec_kind = jhp_pkg::K_HUFF_DONE;
                                r[1].table_slot = cur.slot;
                                n = 2'd2;
                                s.phase = jhp_pkg::P_DHT_HEAD;
                            end
                            else s.phase = jhp_pkg::P_DHT_VAL;
                        end
                    end
                end
                jhp_pkg::P_DHT_VAL:
                begin
                    body_phase = 1'b1;
                    r[0].rec_kind = jhp_pkg::K_HUFF_VALUE;
                    r[0].table_slot = cur.slot;
                    r[0].entry_index = cur.sub_index;
                    r[0].value = {8'd0, b};
                    n = 2'd1;
                    if (k_next >= cur.huff_total)
                    begin
                        r[1].rec_kind = jhp_pkg::K_HUFF_DONE;
                        r[1].table_slot = cur.slot;
                        r[1].value = {7'd0, cur.huff_total};
                        n = 2'd2;
                        s.sub_index = 8'd0;
                        s.phase = jhp_pkg::P_DHT_HEAD;
                    end
                    else s.sub_index = k_next[7:0];
                end
                jhp_pkg::P_DRI:
                begin
                    body_phase = 1'b1;
                    if (cur.sub_index == 8'd0)
                    begin
                        s.field_hold = {8'd0, b}; s.sub_index = 8'd1;
                    end
                    else
                    begin
                        r[0].rec_kind = jhp_pkg::K_RESTART;
                        r[0].value = {cur.field_hold[7:0], b};
                        n = 2'd1;
                        s.phase = jhp_pkg::P_SKIP;
                    end
                end
                jhp_pkg::P_SOS_NS:
                begin
                    body_phase = 1'b1;
                    if (b == 8'd0 || b > 8'(jhp_pkg::MAX_COMPONENTS))
                    begin
                        s.error_code = jhp_pkg::S_COMP_COUNT; s.phase = jhp_pkg::P_ERROR;
                    end
                    else if (rem_after < 16'({b[2:0], 1'b0}) + 16'd3)
                    begin
                        s.error_code = jhp_pkg::S_SHORT; s.phase = jhp_pkg::P_ERROR;
                    end
                    else
                    begin
                        s.comp_total = b[2:0]; s.comp_index = 3'd0; s.sub_index = 8'd0;
                        s.phase = jhp_pkg::P_SOS_COMP;
                    end
                end
                jhp_pkg::P_SOS_COMP:
                begin
                    body_phase = 1'b1;
                    if (cur.sub_index == 8'd0)
                    begin
                        s.field_hold = {8'd0, b}; s.sub_index = 8'd1;
                    end
                    else
                    begin
                        r[0].rec_kind = jhp_pkg::K_SCAN_COMP;
                        r[0].entry_index = {5'd0, cur.comp_index};
                        r[0].comp_ident = cur.field_hold[7:0];
                        r[0].factor_a = b[7:4];
                        r[0].factor_b = b[3:0];
                        n = 2'd1;
                        s.sub_index = 8'd0;
                        s.comp_index = cur.comp_index + 3'd1;
                        if (s.comp_index >= cur.comp_total) s.phase = jhp_pkg::P_SKIP;
                    end
                end
                jhp_pkg::P_SKIP:
                    body_phase = 1'b1;
                default:
                    body_phase = 1'b0;
            endcase
            if (body_phase)
            begin
                s.segment_left = rem_after;
                if (s.phase != jhp_pkg::P_ERROR && rem_after == 16'd0)
                begin
                    if (cur.marker == jhp_pkg::M_SOS && s.phase == jhp_pkg::P_SKIP)
                    begin
                        s.scan_start = size[jhp_pkg::OFFSET_BITS-1:0];
                        s.phase = jhp_pkg::P_SCAN;
                    end
                    else s.phase = jhp_pkg::P_MARK;
                end
            end
        end
        if (file_end)
        begin
            r[n].rec_kind = jhp_pkg::K_FINAL;
            if (size < 4) st = jhp_pkg::S_BAD_START;
            else if (s.phase == jhp_pkg::P_ERROR) st = s.error_code;
            else if (s.phase == jhp_pkg::P_SCAN)
            begin
                if ({1'b0, s.scan_start} >= size) st = jhp_pkg::S_NO_SCAN;
                else
                begin
                    st = jhp_pkg::S_OK;
                    if (s.last_two == {jhp_pkg::M_FF, jhp_pkg::M_EOI}) stop = size - 2'd2;
                    if (stop > {1'b0, s.scan_start})
                        r[n].scan_length = stop[jhp_pkg::OFFSET_BITS-1:0] - s.scan_start;
                    r[n].scan_offset = s.scan_start;
                    r[n].entry_index = {5'd0, s.comp_total};
                end
            end
            else if (s.phase == jhp_pkg::P_MARK) st = jhp_pkg::S_NO_SCAN;
            else st = jhp_pkg::S_TRUNCATED;
            r[n].status = st;
            n = n + 2'd1;
            s = '0;
            s.phase = jhp_pkg::P_SOI0;
        end
        else if (cur.byte_count < OFF_MAX)
            s.byte_count = cur.byte_count + 1'b1;
    end

    assign nxt = s;
    assign rec0 = r[0];
    assign rec1 = r[1];
    assign rec2 = r[2];
    assign rec_count = n;
endmodule
`default_nettype wire

/* hw/rtl/jpeg_header_parser_core.sv */
// Top level of the streaming JPEG marker segment parser.
// Depends on jhp_pkg and jhp_step.
`default_nettype none
// Usage:
// The input channel (in_valid/in_ready) carries one file byte per word, with
// file_end high on the last byte of a file. The output channel
// (out_valid/out_ready) carries one record per word: table and field writes
// found in SOF0, DQT, DHT, DRI and SOS segments, and a final record with status,
// scan offset and scan length on the last byte of each file.
// Each accepted byte yields zero to three records. The byte is decoded in the
// cycle it is accepted and its records land in a three-entry result buffer, so
// the first record shows in the cycle after the byte. A new byte is taken every
// cycle while the buffer is empty or drains its last record in that cycle;
// a byte that yields several records therefore holds the input until the single
// output port passes its last. Bytes that yield no record go at one per cycle.
// Reset returns the parser to waiting for the SOI marker and empties the
// buffer. When the receiver stalls, the current record holds and the input is
// held off once the buffer still has records to give.
module jpeg_header_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        file_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       rec_kind,
    output logic [1:0]       table_slot,
    output logic [7:0]       entry_index,
    output logic [15:0]      value,
    output logic [15:0]      value_two,
    output logic [7:0]       comp_ident,
    output logic [3:0]       factor_a,
    output logic [3:0]       factor_b,
    output logic [3:0]       status,
    output logic [23:0]      scan_offset,
    output logic [23:0]      scan_length,
    output logic             run_last
);
    jhp_pkg::pstate_t st_reg, st_next;
    jhp_pkg::rec_t    r0, r1, r2;
    jhp_pkg::rec_t    buf_reg [3];
    logic [1:0]       cnt;
    logic [1:0]       left_reg;   // records still to deliver
    logic [1:0]       rd_reg;     // index of the record on the port
    logic             in_fire;
    logic             out_fire;

    jhp_step u_step (
        .cur       (st_reg),
        .data_byte (data_byte),
        .file_end  (file_end),
        .nxt       (st_next),
        .rec0      (r0),
        .rec1      (r1),
        .rec2      (r2),
        .rec_count (cnt)
    );

    assign out_valid = (left_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    // Free when empty or when the last buffered record leaves now.
    assign in_ready  = (left_reg == 2'd0) || (left_reg == 2'd1 && out_ready);
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            st_reg.phase <= jhp_pkg::P_SOI0;
            left_reg <= 2'd0;
            rd_reg <= 2'd0;
        end
        else if (in_fire)
        begin
            st_reg <= st_next;
            left_reg <= cnt;
            rd_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            left_reg <= left_reg - 2'd1;
            rd_reg <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg[0] <= r0;
            buf_reg[1] <= r1;
            buf_reg[2] <= r2;
        end
    end

    assign rec_kind    = buf_reg[rd_reg].rec_kind;
    assign table_slot  = buf_reg[rd_reg].table_slot;
    assign entry_index = buf_reg[rd_reg].entry_index;
    assign value       = buf_reg[rd_reg].value;
    assign value_two   = buf_reg[rd_reg].value_two;
    assign comp_ident  = buf_reg[rd_reg].comp_ident;
    assign factor_a    = buf_reg[rd_reg].factor_a;
    assign factor_b    = buf_reg[rd_reg].factor_b;
    assign status      = buf_reg[rd_reg].status;
    assign scan_offset = buf_reg[rd_reg].scan_offset;
    assign scan_length = buf_reg[rd_reg].scan_length;
    assign run_last    = (left_reg == 2'd1);

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (left_reg == 2'd0 || out_fire))
        else $error("byte accepted while records remain");
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, rd_reg} + {1'b0, left_reg} <= 3'd3))
        else $error("record index out of range");
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && file_end) |=> (st_reg.phase == jhp_pkg::P_SOI0))
        else $error("parser not reset after last byte");
    a_final_record: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && file_end) |=> (left_reg != 2'd0))
        else $error("last byte gave no final record");
endmodule
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for jpeg_header_parser_core: streams JPEG files one byte per word,
// predicts every record in a scoreboard class and checks the output channel against it.
// Depends on jhp_pkg and the parser RTL.
module tb_top;
    import jhp_pkg::*;

    typedef struct {
        rec_t r;
        bit   last;
    } parse_rec_t;

    // Tracks the parser state for each accepted byte and holds the records it must give.
    class jpeg_scoreboard;
        parse_rec_t expected_q[$];
        parse_rec_t step_q[$];
        int         errors;

        logic [4:0]  phase;
        longint      count;
        longint      scan_start;
        int          seg_left, marker, len_hi, sub, slot, total, cidx, ctot, hold, fwidth;
        logic [3:0]  err;
        logic [15:0] last2;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase = P_SOI0;
            count = 0; scan_start = 0; seg_left = 0; marker = 0; len_hi = 0; sub = 0;
            slot = 0; total = 0; cidx = 0; ctot = 0; hold = 0; fwidth = 0;
            err = S_OK; last2 = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void halt(logic [3:0] code);
            err = code;
            phase = P_ERROR;
        endfunction

        function void emit(logic [3:0] k, int sl, int ei, int v);
            parse_rec_t e;
            e.r = '0;
            e.last = 0;
            e.r.rec_kind = k;
            e.r.table_slot = sl[1:0];
            e.r.entry_index = ei[7:0];
            e.r.value = v[15:0];
            step_q.push_back(e);
        endfunction

        function void set_comp(int id, int fa, int fb);
            step_q[step_q.size()-1].r.comp_ident = id[7:0];
            step_q[step_q.size()-1].r.factor_a = fa[3:0];
            step_q[step_q.size()-1].r.factor_b = fb[3:0];
        endfunction

        // One byte inside a segment body, with the body bytes left after it.
        function void body_byte(int b, int rem);
            int k;
            case (phase)
                P_SOF_PREC:
                    if (b != 8) halt(S_PRECISION);
                    else begin
                        sub = 0; hold = 0; fwidth = 0; phase = P_SOF_DIM;
                    end
                P_SOF_DIM: begin
                    if (sub < 2) hold = ((hold << 8) | b) & 16'hFFFF;
                    else fwidth = ((fwidth << 8) | b) & 16'hFFFF;
                    sub++;
                    if (sub >= 4) phase = P_SOF_NC;
                end
                P_SOF_NC:
                    if (b == 0 || b > MAX_COMPONENTS) halt(S_COMP_COUNT);
                    else if (rem < 3 * b) halt(S_SHORT);
                    else begin
                        emit(K_DIMS, 0, b, hold);
                        step_q[step_q.size()-1].r.value_two = fwidth[15:0];
                        ctot = b; cidx = 0; sub = 0; phase = P_SOF_COMP;
                    end
                P_SOF_COMP:
                    if (sub == 0) begin hold = b; sub = 1; end
                    else if (sub == 1) begin hold = hold | (b << 8); sub = 2; end
                    else begin
                        emit(K_SOF_COMP, 0, cidx, b);
                        set_comp(hold & 8'hFF, (hold >> 12) & 4'hF, (hold >> 8) & 4'hF);
                        sub = 0; cidx++;
                        if (cidx >= ctot) phase = P_SKIP;
                    end
                P_DQT_HEAD:
                    if ((b >> 4) != 0) halt(S_PRECISION);
                    else if ((b & 4'hF) >= 4) halt(S_TABLE_ID);
                    else if (rem < 64) halt(S_SHORT);
                    else begin
                        slot = b & 3; sub = 0; phase = P_DQT_DATA;
                    end
                P_DQT_DATA: begin
                    emit(K_QUANT, slot, sub, b);
                    sub++;
                    if (sub >= 64) phase = P_DQT_HEAD;
                end
                P_DHT_HEAD:
                    if (rem < 16) phase = P_SKIP;
                    else if ((b >> 4) > 1 || (b & 4'hF) > 1) halt(S_TABLE_ID);
                    else begin
                        slot = ((b >> 4) * 2 + (b & 1)) & 3;
                        total = 0; sub = 0; phase = P_DHT_COUNT;
                    end
                P_DHT_COUNT: begin
                    emit(K_HUFF_COUNT, slot, sub, b);
                    total += b;
                    if (total > 257) total = 257;
                    sub++;
                    if (sub >= 16) begin
                        if (total > 256) halt(S_BAD_LENGTH);
                        else if (rem < total) halt(S_SHORT);
                        else begin
                            sub = 0;
                            if (total == 0) begin
                                emit(K_HUFF_DONE, slot, 0, 0);
                                phase = P_DHT_HEAD;
                            end else phase = P_DHT_VAL;
                        end
                    end
                end
                P_DHT_VAL: begin
                    k = sub;
                    emit(K_HUFF_VALUE, slot, k & 8'hFF, b);
                    k++;
                    if (k >= total) begin
                        emit(K_HUFF_DONE, slot, 0, total);
                        sub = 0; phase = P_DHT_HEAD;
                    end else sub = k & 8'hFF;
                end
                P_DRI:
                    if (sub == 0) begin hold = b; sub = 1; end
                    else begin
                        emit(K_RESTART, 0, 0, ((hold << 8) | b) & 16'hFFFF);
                        phase = P_SKIP;
                    end
                P_SOS_NS:
                    if (b == 0 || b > MAX_COMPONENTS) halt(S_COMP_COUNT);
                    else if (rem < 2 * b + 3) halt(S_SHORT);
                    else begin
                        ctot = b; cidx = 0; sub = 0; phase = P_SOS_COMP;
                    end
                P_SOS_COMP:
                    if (sub == 0) begin hold = b; sub = 1; end
                    else begin
                        emit(K_SCAN_COMP, 0, cidx, 0);
                        set_comp(hold & 8'hFF, (b >> 4) & 4'hF, b & 4'hF);
                        sub = 0; cidx++;
                        if (cidx >= ctot) phase = P_SKIP;
                    end
                default: ;
            endcase
        endfunction

        function void length_done(int b);
            int len;
            int body;
            len = ((len_hi << 8) | b) & 16'hFFFF;
            if (len < 2) begin
                halt(S_BAD_LENGTH);
                return;
            end
            body = len - 2;
            seg_left = body;
            case (marker[7:0])
                M_SOF0: if (body < 6) halt(S_SHORT); else phase = P_SOF_PREC;
                M_DQT: phase = (body != 0) ? P_DQT_HEAD : P_MARK;
                M_DHT: phase = (body != 0) ? P_DHT_HEAD : P_MARK;
                M_DRI:
                    if (body < 2) halt(S_SHORT);
                    else begin sub = 0; phase = P_DRI; end
                M_SOS: if (body < 1) halt(S_SHORT); else phase = P_SOS_NS;
                default: phase = (body != 0) ? P_SKIP : P_MARK;
            endcase
        endfunction

        function void parse_byte(int b);
            int rem;
            case (phase)
                P_SOI0: begin
                    if (b != M_FF) halt(S_BAD_START); else phase = P_SOI1;
                    return;
                end
                P_SOI1: begin
                    if (b != M_SOI) halt(S_BAD_START); else phase = P_MARK;
                    return;
                end
                P_MARK: begin
                    if (b != M_FF) halt(S_NO_MARKER); else phase = P_CODE;
                    return;
                end
                P_CODE: begin
                    // Fill bytes stay here; lone SOI and EOI need no length.
                    if (b == M_FF) return;
                    if (b == M_SOI || b == M_EOI) begin phase = P_MARK; return; end
                    marker = b;
                    phase = P_LEN_HI;
                    return;
                end
                P_LEN_HI: begin len_hi = b; phase = P_LEN_LO; return; end
                P_LEN_LO: begin length_done(b); return; end
                P_SCAN, P_ERROR: return;
                default: ;
            endcase
            if (phase > P_SKIP) return;
            rem = (seg_left != 0) ? seg_left - 1 : 0;
            body_byte(b, rem);
            seg_left = rem;
            if (phase != P_ERROR && seg_left == 0) begin
                if (marker == M_SOS && phase == P_SKIP) begin
                    scan_start = count + 1;
                    phase = P_SCAN;
                end else phase = P_MARK;
            end
        endfunction

        // Called for every accepted input word.
        function void note_byte(logic [7:0] b, bit fend);
            longint     size;
            longint     stop;
            longint     off;
            longint     len;
            int         cnt;
            logic [3:0] st;
            size = count + 1;
            step_q.delete();
            last2 = {last2[7:0], b};
            if (phase != P_ERROR && count >= (64'd1 << OFFSET_BITS) - 1) halt(S_OVERSIZE);
            if (!(fend && phase == P_MARK)) parse_byte(b);
            if (fend) begin
                off = 0; len = 0; cnt = 0;
                if (size < 4) st = S_BAD_START;
                else if (phase == P_ERROR) st = err;
                else if (phase == P_SCAN) begin
                    if (scan_start >= size) st = S_NO_SCAN;
                    else begin
                        st = S_OK;
                        stop = size;
                        if (last2 == {M_FF, M_EOI}) stop = size - 2;
                        len = (stop > scan_start) ? stop - scan_start : 0;
                        off = scan_start;
                        cnt = ctot;
                    end
                end else if (phase == P_MARK) st = S_NO_SCAN;
                else st = S_TRUNCATED;
                emit(K_FINAL, 0, cnt, 0);
                step_q[step_q.size()-1].r.status = st;
                step_q[step_q.size()-1].r.scan_offset = off[OFFSET_BITS-1:0];
                step_q[step_q.size()-1].r.scan_length = len[OFFSET_BITS-1:0];
                clear_state();
            end else if (count < (64'd1 << OFFSET_BITS) - 1) count++;
            if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
            foreach (step_q[i]) expected_q.push_back(step_q[i]);
        endfunction

        function bit field_bad(string nm, longint e, longint a);
            if (e != a) begin
                $display("%0t mismatch %s: expected %0h, actual %0h", $time, nm, e, a);
                return 1;
            end
            return 0;
        endfunction

        // Called for every accepted output word.
        function void check_rec(rec_t a, bit last);
            parse_rec_t e;
            bit         bad;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected record, kind %0d", $time, a.rec_kind);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            bad = 0;
            bad |= field_bad("rec_kind", e.r.rec_kind, a.rec_kind);
            bad |= field_bad("table_slot", e.r.table_slot, a.table_slot);
            bad |= field_bad("entry_index", e.r.entry_index, a.entry_index);
            bad |= field_bad("value", e.r.value, a.value);
            bad |= field_bad("value_two", e.r.value_two, a.value_two);
            bad |= field_bad("comp_ident", e.r.comp_ident, a.comp_ident);
            bad |= field_bad("factor_a", e.r.factor_a, a.factor_a);
            bad |= field_bad("factor_b", e.r.factor_b, a.factor_b);
            bad |= field_bad("status", e.r.status, a.status);
            bad |= field_bad("scan_offset", e.r.scan_offset, a.scan_offset);
            bad |= field_bad("scan_length", e.r.scan_length, a.scan_length);
            bad |= field_bad("run_last", e.last, last);
            if (bad) errors++;
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        file_end;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  rec_kind;
    logic [1:0]  table_slot;
    logic [7:0]  entry_index;
    logic [15:0] value;
    logic [15:0] value_two;
    logic [7:0]  comp_ident;
    logic [3:0]  factor_a;
    logic [3:0]  factor_b;
    logic [3:0]  status;
    logic [23:0] scan_offset;
    logic [23:0] scan_length;
    logic        run_last;

    jpeg_scoreboard sb;
    logic [7:0]     file_q[$];   // the JPEG file being built
    logic [7:0]     body_q[$];   // body of the segment being built
    bit             calm;        // when set, neither side idles but for the long receiver stall
    int             idle_cycles;

    jpeg_header_parser_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .file_end(file_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .rec_kind(rec_kind), .table_slot(table_slot), .entry_index(entry_index),
        .value(value), .value_two(value_two), .comp_ident(comp_ident),
        .factor_a(factor_a), .factor_b(factor_b), .status(status),
        .scan_offset(scan_offset), .scan_length(scan_length), .run_last(run_last)
    );

    initial clk = 0;
    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Check every record the parser hands over, and watch for a hung handshake.
    always @(posedge clk) begin
        rec_t r;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                r.rec_kind = rec_kind; r.table_slot = table_slot;
                r.entry_index = entry_index; r.value = value; r.value_two = value_two;
                r.comp_ident = comp_ident; r.factor_a = factor_a; r.factor_b = factor_b;
                r.status = status; r.scan_offset = scan_offset;
                r.scan_length = scan_length;
                sb.check_rec(r, run_last);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver. It stalls at random, and once for a long stretch so that the result
    // buffer fills and the parser has to hold off the byte stream.
    initial begin
        int k;
        out_ready = 0;
        k = 0;
        @(posedge rst_n);
        forever begin
            out_ready <= 1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            k++;
            if (k == 12) begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
            end else if (!calm) begin
                out_ready <= 0;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    task send_byte(input logic [7:0] b, input bit fend);
        int g;
        g = calm ? 0 : pick_gap();
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        data_byte <= b;
        file_end <= fend;
        do @(posedge clk); while (!in_ready);
        sb.note_byte(b, fend);
    endtask

    task send_file();
        calm = ($urandom_range(0, 3) == 0);
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
        file_q.delete();
    endtask

    task start_file();
        file_q = {M_FF, M_SOI};
    endtask

    // Appends the marker, the length and the body held in body_q.
    task put_seg(input logic [7:0] m);
        int len;
        len = body_q.size() + 2;
        file_q.push_back(M_FF);
        file_q.push_back(m);
        file_q.push_back(len[15:8]);
        file_q.push_back(len[7:0]);
        foreach (body_q[i]) file_q.push_back(body_q[i]);
        body_q.delete();
    endtask

    task put_random(input int n);
        repeat (n) body_q.push_back($urandom_range(0, 255));
    endtask

    task put_sos(input int ns, input logic [7:0] tail);
        body_q.push_back(ns);
        for (int i = 0; i < ns; i++) begin
            body_q.push_back($urandom_range(0, 255));
            body_q.push_back($urandom_range(0, 255));
        end
        body_q.push_back(8'd0);
        body_q.push_back(8'd63);
        body_q.push_back(tail);
        put_seg(M_SOS);
    endtask

    task put_sof(input int nc);
        body_q = {8'd8, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(nc)};
        put_random(3 * nc);
        put_seg(M_SOF0);
    endtask

    task put_dqt(input int tables);
        repeat (tables) begin
            body_q.push_back($urandom_range(0, 3));
            put_random(64);
        end
        put_seg(M_DQT);
    endtask

    task put_dht(input int tables, input int junk);
        int n;
        repeat (tables) begin
            body_q.push_back({3'd0, 1'($urandom_range(0, 1)), 3'd0, 1'($urandom_range(0, 1))});
            n = 0;
            for (int i = 0; i < 16; i++) begin
                body_q.push_back(($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : 0);
                n += body_q[body_q.size()-1];
            end
            put_random(n);
        end
        put_random(junk);
        put_seg(M_DHT);
    endtask

    task put_scan(input int n, input bit eoi);
        repeat (n) file_q.push_back($urandom_range(0, 255));
        if (eoi) file_q = {file_q, M_FF, M_EOI};
    endtask

    task random_file();
        int r;
        int i;
        start_file();
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) file_q.push_back(M_FF);
            r = $urandom_range(0, 99);
            if (r < 10) file_q = {file_q, M_FF, ($urandom_range(0, 1) ? M_SOI : M_EOI)};
            else if (r < 25) put_dqt($urandom_range(1, 2));
            else if (r < 45) put_dht($urandom_range(1, 2),
                                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0);
            else if (r < 58) begin put_random(2); put_seg(M_DRI); end
            else if (r < 78) put_sof($urandom_range(1, MAX_COMPONENTS));
            else begin
                put_random($urandom_range(0, 8));
                put_seg(8'hE0 | 8'($urandom_range(0, 15)));
            end
        end
        if ($urandom_range(0, 9) != 0) put_sos($urandom_range(1, MAX_COMPONENTS),
                                               $urandom_range(0, 255));
        put_scan($urandom_range(0, 30), $urandom_range(0, 4) != 0);
        // Broken files: a corrupted byte or a cut-off tail.
        r = $urandom_range(0, 99);
        if (r < 15) begin
            i = $urandom_range(0, file_q.size() - 1);
            file_q[i] = $urandom_range(0, 255);
        end else if (r < 22) begin
            i = $urandom_range(1, file_q.size());
            while (file_q.size() > i) void'(file_q.pop_back());
        end
    endtask

    initial begin
        int sent;
        sb = new();
        idle_cycles = 0;
        calm = 0;
        rst_n = 0;
        in_valid = 0;
        data_byte = '0;
        file_end = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // A complete file: fill bytes, lone markers, an unknown segment and every table type.
        start_file();
        file_q = {file_q, M_FF, M_FF, M_SOI};
        put_random(4); put_seg(8'hE1);
        body_q.push_back(8'h00);
        for (int i = 0; i < 64; i++) body_q.push_back(i);
        body_q.push_back(8'h03);
        repeat (64) body_q.push_back(8'hFF);
        put_seg(M_DQT);
        body_q = {8'h11, 8'd1, 8'd2};
        repeat (14) body_q.push_back(8'd0);
        body_q = {body_q, 8'h00, 8'hFF, 8'h5A};
        put_seg(M_DHT);
        body_q = {8'hFF, 8'hFF}; put_seg(M_DRI);
        body_q = {8'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd4, 8'd1, 8'h22, 8'd0,
                  8'd2, 8'h11, 8'd1, 8'd3, 8'h11, 8'd1, 8'hFF, 8'hFF, 8'd3};
        put_seg(M_SOF0);
        file_q = {file_q, M_FF, M_EOI};
        put_sos(4, 8'd0);
        file_q = {file_q, 8'h12, M_FF, 8'h00, 8'h34};
        put_scan(0, 1);
        send_file();
        // File too short to hold a marker.
        file_q = {M_FF, M_SOI, M_FF}; send_file();
        // Wrong start of image.
        file_q = {8'h00, M_SOI, M_FF, M_EOI}; send_file();
        // Missing marker after SOI.
        file_q = {M_FF, M_SOI, 8'h12, 8'h34}; send_file();
        // Length under two.
        start_file(); file_q = {file_q, M_FF, 8'hE2, 8'h00, 8'h01, 8'h00}; send_file();
        // Twelve-bit precision in SOF0.
        start_file(); body_q = {8'd12, 8'd0, 8'd8, 8'd0, 8'd8, 8'd1, 8'd1, 8'h11, 8'd0};
        put_seg(M_SOF0); send_file();
        // Component count of zero in SOF0, then five in SOS.
        start_file(); body_q = {8'd8, 8'd0, 8'd8, 8'd0, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0};
        put_seg(M_SOF0); send_file();
        start_file(); body_q = {8'd5}; put_random(13); put_seg(M_SOS); send_file();
        // Quant table id four, and sixteen-bit quant precision.
        start_file(); body_q = {8'h04}; put_random(64); put_seg(M_DQT); send_file();
        start_file(); body_q = {8'h10}; put_random(128); put_seg(M_DQT); send_file();
        // Huffman class two.
        start_file(); body_q = {8'h20}; put_random(20); put_seg(M_DHT); send_file();
        // Huffman counts that sum past 256.
        start_file(); body_q = {8'h00}; repeat (16) body_q.push_back(8'd17);
        put_seg(M_DHT); send_file();
        // Huffman counts that need more bytes than the segment holds.
        start_file(); body_q = {8'h01, 8'd5}; repeat (15) body_q.push_back(8'd0);
        put_random(2); put_seg(M_DHT); send_file();
        // SOF0 body too small, then an SOS whose length leaves too little room.
        start_file(); put_random(4); put_seg(M_SOF0); send_file();
        start_file(); body_q = {8'd2, 8'd1, 8'd0, 8'd0}; put_seg(M_SOS); send_file();
        // A DHT tail under 17 bytes is passed over, then a normal scan follows.
        start_file(); put_dht(1, 9); put_sos(1, 8'd0); put_scan(5, 1); send_file();
        // Last byte falls where a marker is expected.
        file_q = {M_FF, M_SOI, M_FF, M_EOI, M_FF}; send_file();
        // File ends inside a segment body.
        start_file(); file_q = {file_q, M_FF, 8'hE3, 8'h00, 8'h0A, 8'h01}; send_file();
        // The SOS segment ends on the last byte.
        start_file(); put_sos(2, 8'd0); send_file();
        // EOI straddles the end of the SOS segment: the trimmed length would be negative.
        start_file(); put_sos(1, M_FF); file_q.push_back(M_EOI); send_file();
        // Headers only, no scan at all.
        start_file(); put_sof(3); send_file();

        // Random files, mostly well formed.
        sent = 0;
        while (sent < 380) begin
            random_file();
            sent += file_q.size();
            send_file();
        end
        in_valid <= 0;

        while (sb.pending() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/jhp_pkg.sv
hw/rtl/jhp_step.sv
hw/rtl/jpeg_header_parser_core.sv
test/tb_top.sv
